// ----- hw/rtl/gmcp_pkg.sv -----
// Shared types and constants for the grid minimum-cost path block.
// Used by gmcp_if.sv, gmcp_cell.sv and grid_min_cost_path.sv.
package gmcp_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int HEIGHT_BITS = 16;
   localparam int COST_BITS   = 22;
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int DIM_BITS    = 7;
   localparam int ADDR_BITS   = $clog2(MAX_ROWS * MAX_COLS);
   localparam int COUNT_BITS  = 13;
   localparam int ELEV_BITS   = 16;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_ROWS    = 1'b1;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(64);

   typedef enum logic [1:0] {
      MOVE_STRAIGHT = 2'd0,
      MOVE_DOWN     = 2'd1,
      MOVE_UP       = 2'd2
   } move_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SHIFT,
      ST_DRAIN,
      ST_STEP,
      ST_SELECT,
      ST_PREP,
      ST_EMIT
   } state_type;

   // height of the column to the east and cost from there to the east edge
   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic [COST_BITS-1:0]   cost;
   } cell_link_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic                shift;
      logic                step;
      logic                east;
      logic [COL_BITS-1:0] wr_col;
      logic [COL_BITS-1:0] rd_col;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/gmcp_if.sv -----
// Valid/ready channel interfaces for sample words and path words.
// Depends on gmcp_pkg for field widths.
interface gmcp_req_if;
   logic                              valid;
   logic                              ready;
   logic [gmcp_pkg::ELEV_BITS-1:0]    elevation;

   modport source (output valid, output elevation, input ready);
   modport sink   (input valid, input elevation, output ready);
endinterface

interface gmcp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gmcp_pkg::COL_BITS-1:0]     path_column;
   logic [gmcp_pkg::ROW_BITS-1:0]     path_row;
   logic [gmcp_pkg::COST_BITS-1:0]    path_cost;
   logic                              last_point;

   modport source (output valid, output path_column, output path_row,
                   output path_cost, output last_point, input ready);
   modport sink   (input valid, input path_column, input path_row,
                   input path_cost, input last_point, output ready);
endinterface

// ----- hw/rtl/gmcp_cell.sv -----
// One row cell of the cost chain: holds the row's current height, the east
// column's height and cost, and the row's move history. Depends on gmcp_pkg.
module gmcp_cell (
   input  logic                              clock,
   input  gmcp_pkg::cell_ctrl_type           ctrl,
   input  logic [gmcp_pkg::HEIGHT_BITS-1:0]  height_in,
   output logic [gmcp_pkg::HEIGHT_BITS-1:0]  height_out,
   input  gmcp_pkg::cell_link_type           down_link,
   input  gmcp_pkg::cell_link_type           up_link,
   input  logic                              down_ok,
   input  logic                              up_ok,
   output gmcp_pkg::cell_link_type           own_link,
   output gmcp_pkg::move_type                move_rd
);

   logic [gmcp_pkg::HEIGHT_BITS-1:0] hcur_ff;
   gmcp_pkg::cell_link_type          link_ff;
   gmcp_pkg::cell_link_type          link_in;
   gmcp_pkg::move_type               move_in;
   gmcp_pkg::move_type               move_mem [gmcp_pkg::MAX_COLS];
   gmcp_pkg::move_type               move_rd_ff;
   logic [gmcp_pkg::HEIGHT_BITS-1:0] diff_st, diff_dn, diff_up;
   logic [gmcp_pkg::COST_BITS-1:0]   cost_st, cost_dn, cost_up;

   // absolute height steps to the three targets
   always_comb begin
      diff_st = (hcur_ff >= link_ff.height) ? hcur_ff - link_ff.height
                                            : link_ff.height - hcur_ff;
      diff_dn = (hcur_ff >= down_link.height) ? hcur_ff - down_link.height
                                              : down_link.height - hcur_ff;
      diff_up = (hcur_ff >= up_link.height) ? hcur_ff - up_link.height
                                            : up_link.height - hcur_ff;
      cost_st = gmcp_pkg::COST_BITS'(diff_st) + link_ff.cost;
      cost_dn = gmcp_pkg::COST_BITS'(diff_dn) + down_link.cost;
      cost_up = gmcp_pkg::COST_BITS'(diff_up) + up_link.cost;
   end

   // pick the cheapest move, ties to straight, then down, then up; east column costs zero
   always_comb begin
      link_in.height = hcur_ff;
      link_in.cost   = cost_st;
      move_in        = gmcp_pkg::MOVE_STRAIGHT;
      if (ctrl.east) begin
         link_in.cost = '0;
      end else begin
         if (down_ok && (cost_dn < link_in.cost)) begin
            link_in.cost = cost_dn;
            move_in      = gmcp_pkg::MOVE_DOWN;
         end
         if (up_ok && (cost_up < link_in.cost)) begin
            link_in.cost = cost_up;
            move_in      = gmcp_pkg::MOVE_UP;
         end
      end
   end

   // advance the height chain and commit a column step
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         hcur_ff <= height_in;
      end
      if (ctrl.step) begin
         link_ff <= link_in;
      end
   end

   // move history, one entry per column
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         move_mem[ctrl.wr_col] <= move_in;
      end
      move_rd_ff <= move_mem[ctrl.rd_col];
   end

   assign height_out = hcur_ff;
   assign own_link   = link_ff;
   assign move_rd    = move_rd_ff;

endmodule

// ----- hw/rtl/grid_min_cost_path.sv -----
// Grid minimum-cost path: accepts one elevation word per cycle while loading.
// After the last word each column runs a sweep of height reads (one per row),
// a drain and a step; a best-row search over all rows then precedes the first
// path word. Each path word is preceded by a prep state and waits for ready.
// Reset: sizes return to 64 x 64, load count to zero; stores are not cleared.
// Depends on gmcp_pkg, gmcp_if and gmcp_cell.
module grid_min_cost_path (
   input  logic                                clock,
   input  logic                                reset,
   gmcp_req_if.sink                            req_chan,
   gmcp_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [gmcp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [gmcp_pkg::DIM_BITS-1:0]       csr_wdata
);

   localparam int NR = gmcp_pkg::MAX_ROWS;

   gmcp_pkg::state_type                 state_ff, state_in;
   logic [gmcp_pkg::DIM_BITS-1:0]       cols_cfg_ff, rows_cfg_ff;
   logic [gmcp_pkg::DIM_BITS-1:0]       cols_eff, rows_eff;
   logic [gmcp_pkg::COUNT_BITS-1:0]     load_cnt_ff, load_cnt_in, load_next, total;
   logic [gmcp_pkg::ADDR_BITS-1:0]      base_ff, base_in, addr_ff, addr_in;
   logic [gmcp_pkg::ROW_BITS-1:0]       rcnt_ff, rcnt_in;
   logic [gmcp_pkg::COL_BITS-1:0]       col_ff, col_in;
   logic [gmcp_pkg::ROW_BITS-1:0]       sel_ff, sel_in, row_ff, row_in;
   logic [gmcp_pkg::COST_BITS-1:0]      best_ff, best_in;
   logic                                rdv_ff;
   logic [gmcp_pkg::HEIGHT_BITS-1:0]    rd_data_ff;
   logic [gmcp_pkg::HEIGHT_BITS-1:0]    height_mem [NR * gmcp_pkg::MAX_COLS];
   logic                                req_fire, rsp_fire, load_done;
   logic                                last_col, last_row_sel;
   logic [gmcp_pkg::COL_BITS-1:0]       cols_m1;
   logic [gmcp_pkg::ROW_BITS-1:0]       rows_m1;
   gmcp_pkg::cell_ctrl_type             ctrl;
   gmcp_pkg::cell_link_type             links [NR];
   logic [gmcp_pkg::HEIGHT_BITS-1:0]    hchain [NR];
   gmcp_pkg::move_type                  moves [NR];
   gmcp_pkg::move_type                  move_sel;
   logic [gmcp_pkg::COST_BITS-1:0]      cost_sel;

   // saturate sizes to the supported range
   always_comb begin
      cols_eff = (cols_cfg_ff == '0) ? gmcp_pkg::DIM_BITS'(1) :
                 (cols_cfg_ff > gmcp_pkg::DIM_BITS'(gmcp_pkg::MAX_COLS)) ?
                 gmcp_pkg::DIM_BITS'(gmcp_pkg::MAX_COLS) : cols_cfg_ff;
      rows_eff = (rows_cfg_ff == '0) ? gmcp_pkg::DIM_BITS'(1) :
                 (rows_cfg_ff > gmcp_pkg::DIM_BITS'(NR)) ?
                 gmcp_pkg::DIM_BITS'(NR) : rows_cfg_ff;
      total    = gmcp_pkg::COUNT_BITS'(cols_eff) * gmcp_pkg::COUNT_BITS'(rows_eff);
      cols_m1  = gmcp_pkg::COL_BITS'(cols_eff - gmcp_pkg::DIM_BITS'(1));
      rows_m1  = gmcp_pkg::ROW_BITS'(rows_eff - gmcp_pkg::DIM_BITS'(1));
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= gmcp_pkg::DIM_RESET;
         rows_cfg_ff <= gmcp_pkg::DIM_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            gmcp_pkg::CSR_GRID_COLUMNS: cols_cfg_ff <= csr_wdata;
            gmcp_pkg::CSR_GRID_ROWS:    rows_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign rsp_fire     = rsp_chan.valid && rsp_chan.ready;
   assign load_next    = load_cnt_ff + gmcp_pkg::COUNT_BITS'(1);
   assign load_done    = load_next >= total;
   assign last_col     = (col_ff == cols_m1);
   assign last_row_sel = (sel_ff == rows_m1);
   assign cost_sel     = links[sel_ff].cost;
   assign move_sel     = moves[row_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmcp_pkg::ST_LOAD:   if (req_fire && load_done) state_in = gmcp_pkg::ST_SHIFT;
         gmcp_pkg::ST_SHIFT:  if (rcnt_ff == '0) state_in = gmcp_pkg::ST_DRAIN;
         gmcp_pkg::ST_DRAIN:  state_in = gmcp_pkg::ST_STEP;
         gmcp_pkg::ST_STEP:   state_in = (col_ff == '0) ? gmcp_pkg::ST_SELECT
                                                        : gmcp_pkg::ST_SHIFT;
         gmcp_pkg::ST_SELECT: if (last_row_sel) state_in = gmcp_pkg::ST_PREP;
         gmcp_pkg::ST_PREP:   state_in = gmcp_pkg::ST_EMIT;
         gmcp_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               state_in = last_col ? gmcp_pkg::ST_LOAD : gmcp_pkg::ST_PREP;
            end
         end
         default: state_in = gmcp_pkg::ST_LOAD;
      endcase
   end

   // outputs decoded from state
   always_comb begin
      req_chan.ready = (state_ff == gmcp_pkg::ST_LOAD);
      rsp_chan.valid = (state_ff == gmcp_pkg::ST_EMIT);
      ctrl.shift     = rdv_ff;
      ctrl.step      = (state_ff == gmcp_pkg::ST_STEP);
      ctrl.east      = last_col;
      ctrl.wr_col    = col_ff;
      ctrl.rd_col    = col_ff;
   end

   assign rsp_chan.path_column = col_ff;
   assign rsp_chan.path_row    = row_ff;
   assign rsp_chan.path_cost   = best_ff;
   assign rsp_chan.last_point  = last_col;

   // datapath next values
   always_comb begin
      load_cnt_in = load_cnt_ff;
      base_in     = base_ff;
      addr_in     = addr_ff;
      rcnt_in     = rcnt_ff;
      col_in      = col_ff;
      sel_in      = sel_ff;
      row_in      = row_ff;
      best_in     = best_ff;
      case (state_ff)
         gmcp_pkg::ST_LOAD: begin
            if (req_fire) begin
               load_cnt_in = load_done ? '0 : load_next;
               base_in     = gmcp_pkg::ADDR_BITS'(total - gmcp_pkg::COUNT_BITS'(1));
               addr_in     = gmcp_pkg::ADDR_BITS'(total - gmcp_pkg::COUNT_BITS'(1));
               rcnt_in     = rows_m1;
               col_in      = cols_m1;
            end
         end
         gmcp_pkg::ST_SHIFT: begin
            addr_in = addr_ff - gmcp_pkg::ADDR_BITS'(cols_eff);
            rcnt_in = rcnt_ff - gmcp_pkg::ROW_BITS'(1);
         end
         gmcp_pkg::ST_STEP: begin
            if (col_ff == '0) begin
               sel_in  = '0;
               row_in  = '0;
               best_in = '1;
            end else begin
               col_in  = col_ff - gmcp_pkg::COL_BITS'(1);
               base_in = base_ff - gmcp_pkg::ADDR_BITS'(1);
               addr_in = base_ff - gmcp_pkg::ADDR_BITS'(1);
               rcnt_in = rows_m1;
            end
         end
         gmcp_pkg::ST_SELECT: begin
            if (cost_sel < best_ff) begin
               best_in = cost_sel;
               row_in  = sel_ff;
            end
            sel_in = sel_ff + gmcp_pkg::ROW_BITS'(1);
            if (last_row_sel) col_in = '0;
         end
         gmcp_pkg::ST_EMIT: begin
            if (rsp_fire && !last_col) begin
               col_in = col_ff + gmcp_pkg::COL_BITS'(1);
               if (move_sel == gmcp_pkg::MOVE_DOWN && row_ff != rows_m1) begin
                  row_in = row_ff + gmcp_pkg::ROW_BITS'(1);
               end else if (move_sel == gmcp_pkg::MOVE_UP && row_ff != '0) begin
                  row_in = row_ff - gmcp_pkg::ROW_BITS'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gmcp_pkg::ST_LOAD;
         load_cnt_ff <= '0;
         rdv_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         rdv_ff      <= (state_ff == gmcp_pkg::ST_SHIFT);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff <= base_in;
      addr_ff <= addr_in;
      rcnt_ff <= rcnt_in;
      col_ff  <= col_in;
      sel_ff  <= sel_in;
      row_ff  <= row_in;
      best_ff <= best_in;
   end

   // height store: write while loading, read one row per cycle while sweeping
   always_ff @(posedge clock) begin
      if (req_fire) begin
         height_mem[load_cnt_ff[gmcp_pkg::ADDR_BITS-1:0]] <=
            req_chan.elevation[gmcp_pkg::HEIGHT_BITS-1:0];
      end
      rd_data_ff <= height_mem[addr_ff];
   end

   // row cells, heights enter at row 0 and move toward higher rows
   for (genvar i = 0; i < NR; i++) begin : g_cell
      gmcp_pkg::cell_link_type          dn_link, up_link;
      logic [gmcp_pkg::HEIGHT_BITS-1:0] h_in;
      if (i == 0) begin : g_first
         assign h_in    = rd_data_ff;
         assign up_link = '0;
      end else begin : g_mid
         assign h_in    = hchain[i-1];
         assign up_link = links[i-1];
      end
      if (i == NR - 1) begin : g_last
         assign dn_link = '0;
      end else begin : g_notlast
         assign dn_link = links[i+1];
      end
      gmcp_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .height_in  (h_in),
         .height_out (hchain[i]),
         .down_link  (dn_link),
         .up_link    (up_link),
         .down_ok    (gmcp_pkg::DIM_BITS'(i + 1) < rows_eff),
         .up_ok      (i != 0),
         .own_link   (links[i]),
         .move_rd    (moves[i])
      );
   end

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("sample accepted while a path word is offered");

   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && load_done) |=> (state_ff == gmcp_pkg::ST_SHIFT))
      else $error("grid completion did not start the sweep");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.last_point) |=>
         (state_ff == gmcp_pkg::ST_LOAD && load_cnt_ff == '0))
      else $error("run end did not return to loading");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (gmcp_pkg::DIM_BITS'(rsp_chan.path_row) < rows_eff))
      else $error("path row beyond grid");

endmodule
